// ===== src/rar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int IN_W  = 16;
   localparam int OPW   = OPERAND_BITS + 1;
   localparam int PRW   = 2 * OPW;
   localparam int SUMW  = PRW + 1;
   localparam int MW    = 2 * OPERAND_BITS;
   localparam int KW    = $clog2(MW);
   localparam int CKW   = 33;
   localparam int NUM_W = 32;
   localparam int DEN_W = 30;
   localparam int ST_W  = 2;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] MUL_P0 = 2'd0;
   localparam logic [1:0] MUL_P1 = 2'd1;
   localparam logic [1:0] MUL_P2 = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       comb;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } rar_cmd_type;

   typedef struct packed {
      logic skip;
      logic gcd_done;
   } rar_stat_type;

endpackage
`default_nettype wire

// ===== src/rar_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rar_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire rar_pkg::rar_stat_type stat,
   output rar_pkg::rar_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL0 = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_COMB = 3'd4;
   localparam logic [2:0] S_GCD  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [rar_pkg::KW-1:0] cnt_ff, cnt_in;
   logic                   vld_ff, vld_in;
   logic                   slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign slot_free  = !vld_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rar_pkg::MUL_P0;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rar_pkg::MUL_P1;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rar_pkg::MUL_P2;
            state_in    = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.skip) begin
               state_in = S_FIN;
            end else if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == rar_pkg::KW'(rar_pkg::MW - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.out_load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/rar_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rar_dp (
   input  wire logic                             clock,
   input  wire rar_pkg::rar_cmd_type             cmd,
   input  wire logic [rar_pkg::OP_W-1:0]         op,
   input  wire logic [rar_pkg::IN_W-1:0]         num_a,
   input  wire logic [rar_pkg::IN_W-1:0]         den_a,
   input  wire logic [rar_pkg::IN_W-1:0]         num_b,
   input  wire logic [rar_pkg::IN_W-1:0]         den_b,
   output rar_pkg::rar_stat_type                 stat,
   output logic [rar_pkg::NUM_W-1:0]             res_num,
   output logic [rar_pkg::DEN_W-1:0]             res_den,
   output logic [rar_pkg::ST_W-1:0]              status
);

   localparam int OPW = rar_pkg::OPW;
   localparam int PRW = rar_pkg::PRW;
   localparam int SUMW = rar_pkg::SUMW;
   localparam int MW  = rar_pkg::MW;
   localparam int KW  = rar_pkg::KW;
   localparam int CKW = rar_pkg::CKW;

   function automatic logic signed [OPW-1:0] sext(input logic [rar_pkg::IN_W-1:0] x);
      logic [rar_pkg::OPERAND_BITS-1:0] v;
      v = x[rar_pkg::OPERAND_BITS-1:0];
      return signed'({v[rar_pkg::OPERAND_BITS-1], v});
   endfunction

   // operand capture
   logic signed [OPW-1:0] nax, dax, nbx, dbx;
   logic signed [OPW-1:0] na_ff, da_ff, nb_ff, db_ff;
   logic [rar_pkg::OP_W-1:0] op_ff;
   logic [rar_pkg::ST_W-1:0] err_ff, err_in;

   assign nax = sext(num_a);
   assign dax = sext(den_a);
   assign nbx = sext(num_b);
   assign dbx = sext(den_b);

   always_comb begin
      if (dax == '0 || dbx == '0) begin
         err_in = rar_pkg::ST_ZERO_DEN;
      end else if (op == rar_pkg::OP_DIV && nbx == '0) begin
         err_in = rar_pkg::ST_DIV_ZERO;
      end else begin
         err_in = rar_pkg::ST_OK;
      end
   end

   // shared multiplier
   logic signed [OPW-1:0] ma, mb;
   logic signed [PRW-1:0] prod;
   logic signed [PRW-1:0] p0_ff, p1_ff, p2_ff;

   always_comb begin
      case (cmd.mul_sel)
         rar_pkg::MUL_P0: begin
            ma = na_ff;
            mb = (op_ff == rar_pkg::OP_MUL) ? nb_ff : db_ff;
         end
         rar_pkg::MUL_P1: begin
            ma = nb_ff;
            mb = da_ff;
         end
         default: begin
            ma = da_ff;
            mb = (op_ff == rar_pkg::OP_DIV) ? nb_ff : db_ff;
         end
      endcase
   end

   assign prod = ma * mb;

   // combine cross products, move sign to numerator
   logic signed [SUMW-1:0] sum, num_s;
   logic signed [PRW-1:0]  den_s;
   logic                   neg_ff, zero_ff;
   logic [MW-1:0]          nmag_ff, dmag_ff, nmag_c, dmag_c;

   always_comb begin
      case (op_ff)
         rar_pkg::OP_ADD: sum = SUMW'(p0_ff) + SUMW'(p1_ff);
         rar_pkg::OP_SUB: sum = SUMW'(p0_ff) - SUMW'(p1_ff);
         default:         sum = SUMW'(p0_ff);
      endcase
      if (p2_ff < 0) begin
         num_s = -sum;
         den_s = -p2_ff;
      end else begin
         num_s = sum;
         den_s = p2_ff;
      end
      nmag_c = (num_s < 0) ? MW'(-num_s) : MW'(num_s);
      dmag_c = MW'(den_s);
   end

   // binary GCD and exact division
   logic [MW-1:0] u_ff, v_ff, g_ff;
   logic [KW-1:0] k_ff;
   logic [MW-1:0] qn_ff, qd_ff, rn_ff, rd_ff;
   logic [MW:0]   tn, td;

   assign stat.gcd_done = (u_ff == v_ff);
   assign stat.skip     = (err_ff != rar_pkg::ST_OK) || zero_ff;

   assign tn = {rn_ff, qn_ff[MW-1]};
   assign td = {rd_ff, qd_ff[MW-1]};

   // result formatting
   logic [CKW-1:0]         qn_x, qd_x;
   logic signed [CKW-1:0]  sres;
   logic                   range_bad;

   always_comb begin
      qn_x = CKW'(qn_ff);
      qd_x = CKW'(qd_ff);
      sres = neg_ff ? -signed'(qn_x) : signed'(qn_x);
      range_bad = (qd_x > CKW'(33'h03FFFFFFF)) ||
                  (neg_ff  && qn_x > CKW'(33'h080000000)) ||
                  (!neg_ff && qn_x > CKW'(33'h07FFFFFFF));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op;
         err_ff <= err_in;
         na_ff  <= (dax < 0) ? -nax : nax;
         da_ff  <= (dax < 0) ? -dax : dax;
         nb_ff  <= (dbx < 0) ? -nbx : nbx;
         db_ff  <= (dbx < 0) ? -dbx : dbx;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            rar_pkg::MUL_P0: p0_ff <= prod;
            rar_pkg::MUL_P1: p1_ff <= prod;
            default:         p2_ff <= prod;
         endcase
      end
      if (cmd.comb) begin
         neg_ff  <= (num_s < 0);
         zero_ff <= (num_s == '0);
         nmag_ff <= nmag_c;
         dmag_ff <= dmag_c;
         u_ff    <= nmag_c;
         v_ff    <= dmag_c;
         k_ff    <= '0;
      end
      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
      if (cmd.div_init) begin
         g_ff  <= u_ff << k_ff;
         rn_ff <= '0;
         rd_ff <= '0;
         qn_ff <= nmag_ff;
         qd_ff <= dmag_ff;
      end
      if (cmd.div_step) begin
         if (tn >= {1'b0, g_ff}) begin
            rn_ff <= MW'(tn - {1'b0, g_ff});
            qn_ff <= {qn_ff[MW-2:0], 1'b1};
         end else begin
            rn_ff <= MW'(tn);
            qn_ff <= {qn_ff[MW-2:0], 1'b0};
         end
         if (td >= {1'b0, g_ff}) begin
            rd_ff <= MW'(td - {1'b0, g_ff});
            qd_ff <= {qd_ff[MW-2:0], 1'b1};
         end else begin
            rd_ff <= MW'(td);
            qd_ff <= {qd_ff[MW-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         if (err_ff != rar_pkg::ST_OK) begin
            res_num <= '0;
            res_den <= '0;
            status  <= err_ff;
         end else if (zero_ff) begin
            res_num <= '0;
            res_den <= rar_pkg::DEN_W'(1);
            status  <= rar_pkg::ST_OK;
         end else if (range_bad) begin
            res_num <= '0;
            res_den <= '0;
            status  <= rar_pkg::ST_RANGE;
         end else begin
            res_num <= rar_pkg::NUM_W'(sres);
            res_den <= rar_pkg::DEN_W'(qd_x);
            status  <= rar_pkg::ST_OK;
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/rational_arith_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Exact arithmetic on two fractions (add, subtract, multiply, divide) with the
// result reduced to lowest terms and a positive denominator; a zero numerator
// gives denominator 1. Operands are read as two's complement in their low
// 16 bits. One transaction in gives one transaction out. Status 1 flags a zero
// input denominator, 2 a division by a zero fraction, 3 a reduced result that
// does not fit res_num/res_den; on any nonzero status both values read 0.
// Items are handled one at a time: the request side is ready only while the
// controller is idle. An item passes through the shared 17x17 multiplier for
// the cross products and the denominator, a combine step, the binary GCD loop
// (one step per cycle) and a check that spots its end, then a bit-serial exact
// division of both magnitudes by the GCD and a load of the result register;
// error and zero-numerator items skip the GCD and division.
// A finished result waits in the output register until taken.
module rational_arith_reduce (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // num_a[15:0], den_a[31:16], num_b[47:32], den_b[63:48]
   input  wire logic [1:0]  req_tuser,  // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // res_num[31:0], res_den[61:32], zero[63:62]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   rar_pkg::rar_cmd_type  cmd;
   rar_pkg::rar_stat_type stat;
   logic [rar_pkg::NUM_W-1:0] res_num;
   logic [rar_pkg::DEN_W-1:0] res_den;
   logic [rar_pkg::ST_W-1:0]  status;

   // sequence the multiply, GCD and division passes
   rar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hold operands, products, GCD state and the result register
   rar_dp u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .op      (req_tuser),
      .num_a   (req_tdata[15:0]),
      .den_a   (req_tdata[31:16]),
      .num_b   (req_tdata[47:32]),
      .den_b   (req_tdata[63:48]),
      .stat    (stat),
      .res_num (res_num),
      .res_den (res_den),
      .status  (status)
   );

   assign rsp_tdata = {2'b00, res_den, res_num};
   assign rsp_tuser = status;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Scoreboard: predicts the reduced fraction for each accepted request and
// compares it with the responses in order.
class frac_scoreboard;
   typedef struct {
      logic [31:0] num;
      logic [29:0] den;
      logic [1:0]  status;
   } frac_result_type;

   frac_result_type pending[$];
   int errors;

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Work out the expected response for one request and queue it.
   function void note_request(logic [1:0] op, logic [63:0] data);
      longint na, da, nb, db, num, den;
      longint unsigned mag, g;
      frac_result_type r;
      na = longint'($signed(data[15:0]));
      da = longint'($signed(data[31:16]));
      nb = longint'($signed(data[47:32]));
      db = longint'($signed(data[63:48]));
      r.num = '0;
      r.den = '0;
      if (da == 0 || db == 0) begin
         r.status = rar_pkg::ST_ZERO_DEN;
      end else begin
         if (da < 0) begin
            na = -na;
            da = -da;
         end
         if (db < 0) begin
            nb = -nb;
            db = -db;
         end
         if (op == rar_pkg::OP_DIV && nb == 0) begin
            r.status = rar_pkg::ST_DIV_ZERO;
         end else begin
            case (op)
               rar_pkg::OP_ADD: begin
                  num = na * db + nb * da;
                  den = da * db;
               end
               rar_pkg::OP_SUB: begin
                  num = na * db - nb * da;
                  den = da * db;
               end
               rar_pkg::OP_MUL: begin
                  num = na * nb;
                  den = da * db;
               end
               default: begin
                  num = na * db;
                  den = da * nb;
               end
            endcase
            if (den < 0) begin
               num = -num;
               den = -den;
            end
            if (num == 0) begin
               den = 1;
            end else begin
               mag = (num < 0) ? longint'(-num) : longint'(num);
               g = gcd_of(mag, den);
               num = num / longint'(g);
               den = den / longint'(g);
            end
            if (num > 64'sd2147483647 || num < -64'sd2147483648 || den > 64'sd1073741823)
               begin
               r.status = rar_pkg::ST_RANGE;
            end else begin
               r.status = rar_pkg::ST_OK;
               r.num = num[31:0];
               r.den = den[29:0];
            end
         end
      end
      pending.push_back(r);
   endfunction

   // Compare one response with the oldest prediction.
   function void check_response(logic [63:0] data, logic [1:0] status);
      frac_result_type e;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected response num=%h den=%h st=%0d",
                     data[31:0], data[61:32], status);
         return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.num || data[61:32] !== e.den || data[63:62] !== 2'b00
          || status !== e.status) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp num=%h den=%h st=%0d, got num=%h den=%h st=%0d raw=%h",
                     e.num, e.den, e.status, data[31:0], data[61:32], status, data);
      end
   endfunction
endclass

module tb_top;

   localparam int N_RANDOM   = 1100;
   localparam int WATCHDOG   = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // num_a[15:0], den_a[31:16], num_b[47:32], den_b[63:48]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // res_num[31:0], res_den[61:32], zero[63:62]
   logic [1:0]  rsp_tuser;   // status[1:0]

   frac_scoreboard fracs;
   int   idle_cycles;

   rational_arith_reduce dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, sometimes none at all.
   function automatic int gap_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return 0;
      if (sel < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Random operand with bias towards the extremes and small values.
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h8001;
         3: return 16'h0000;
         4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   // Drive one request transaction; hold it until accepted.
   task automatic send_fraction(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                                logic [15:0] nb, logic [15:0] db);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {db, nb, da, na};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fracs.note_request(op, {db, nb, da, na});
      @(negedge clock);
   endtask

   // Sample responses at the rising edge; vary the ready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         fracs.check_response(rsp_tdata, rsp_tuser);
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         gap = gap_length();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Watchdog: count cycles with no transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [1:0] op;
      logic [15:0] dens;
      fracs      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rar_pkg::OP_ADD;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation, extremes, each error case.
      send_fraction(rar_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
      send_fraction(rar_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
      send_fraction(rar_pkg::OP_MUL, 16'hfffe, 16'd4, 16'd3, 16'hfffa);
      send_fraction(rar_pkg::OP_DIV, 16'd3, 16'd4, 16'hfffd, 16'd8);
      send_fraction(rar_pkg::OP_ADD, 16'd5, 16'd0, 16'd1, 16'd1);
      send_fraction(rar_pkg::OP_DIV, 16'd1, 16'd1, 16'd7, 16'd0);
      send_fraction(rar_pkg::OP_DIV, 16'd1, 16'd3, 16'd0, 16'd5);
      send_fraction(rar_pkg::OP_DIV, 16'd0, 16'd0, 16'd0, 16'hffff);
      send_fraction(rar_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
      send_fraction(rar_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_fraction(rar_pkg::OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_fraction(rar_pkg::OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_fraction(rar_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_fraction(rar_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe);
      send_fraction(rar_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h7ffd);
      send_fraction(rar_pkg::OP_SUB, 16'h8001, 16'h8001, 16'h7fff, 16'h7fff);
      send_fraction(rar_pkg::OP_ADD, 16'h0000, 16'h8000, 16'h0000, 16'h0001);
      send_fraction(rar_pkg::OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_fraction(rar_pkg::OP_DIV, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
      send_fraction(rar_pkg::OP_SUB, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);

      // Random requests; a few zero denominators slip in via pick_operand.
      repeat (N_RANDOM) begin
         op = 2'($urandom_range(0, 3));
         dens = pick_operand();
         send_fraction(op, pick_operand(), ($urandom_range(0, 3) == 0) ? dens : 16'($urandom),
                       pick_operand(), pick_operand());
      end
      req_tvalid <= 1'b0;

      while (fracs.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fracs.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/rar_pkg.sv
src/rar_ctrl.sv
src/rar_dp.sv
src/rational_arith_reduce.sv
bench/tb_top.sv
